// ===== rtl/sem_pkg.sv =====
// Package with shared types, constants and gradient functions for the Sobel edge block.
`default_nettype none
package sem_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 4096;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int FW_W       = 11;
  localparam int FH_W       = 13;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 11'd1024;
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 13'd1024;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  localparam int SQ_W = 22;
  localparam logic [SQ_W-1:0] SAT_LIMIT = 22'd65280;
  localparam logic [7:0] MAG_MAX = 8'd255;

  localparam int KERN_X [9] = '{-1, 0, 1, -2, 0, 2, -1, 0, 1};
  localparam int KERN_Y [9] = '{-1, -2, -1, 0, 0, 0, 1, 2, 1};

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef logic signed [11:0] grad_t;

  function automatic grad_t sobel_gx(input logic [8:0][7:0] v);
    int acc;
    acc = 0;
    for (int i = 0; i < 9; i++) begin
      acc = acc + KERN_X[i] * int'(v[i]);
    end
    return grad_t'(acc);
  endfunction

  function automatic grad_t sobel_gy(input logic [8:0][7:0] v);
    int acc;
    acc = 0;
    for (int i = 0; i < 9; i++) begin
      acc = acc + KERN_Y[i] * int'(v[i]);
    end
    return grad_t'(acc);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/sem_if.sv =====
// Channel interfaces for pixel input, magnitude output and register writes.
`default_nettype none
interface sem_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] in_red;
  logic [7:0] in_green;
  logic [7:0] in_blue;
  modport source (output valid, op, in_red, in_green, in_blue, input ready);
  modport sink (input valid, op, in_red, in_green, in_blue, output ready);
endinterface

interface sem_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic       end_of_frame;
  modport source (output valid, out_red, out_green, out_blue, end_of_frame, input ready);
  modport sink (input valid, out_red, out_green, out_blue, end_of_frame, output ready);
endinterface

interface sem_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [12:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/sobel_edge_magnitude_3x3_top.sv =====
// Streaming 3x3 Sobel edge magnitude on RGB pixels with two line memories.
//
//  channel | direction | transaction carries
//  in_ch   | in        | op, in_red, in_green, in_blue
//  out_ch  | out       | out_red, out_green, out_blue, end_of_frame
//  cfg_ch  | in        | index, data (frame_width, frame_height)
//
// An item that yields a result passes through update, division of its position by
// the width at one bit per cycle, gradients, squares, the eight-step square root
// and rounding. Other items pass through update only; a surplus pixel is dropped.
// Reset is synchronous and needs no clearing pass. The finished result waits in the
// output register while the next item is taken; the core stalls only when a second
// result is ready before the first one leaves.
`default_nettype none
module sobel_edge_magnitude_3x3_top import sem_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic      clk,
  input  logic      rst_n,
  sem_in_if.sink    in_ch,
  sem_out_if.source out_ch,
  sem_cfg_if.sink   cfg_ch
);

  localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int TOT_W = WW + HW;
  localparam int POS_W = TOT_W + 1;
  localparam int CNT_W = $clog2(POS_W + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_UPD, S_DIV, S_GRAD, S_SQ, S_ROOT, S_RND
  } state_t;

  state_t state_r;

  logic [FW_W-1:0]  frame_width_r;
  logic [FH_W-1:0]  frame_height_r;
  logic [POS_W-1:0] pos_r;
  logic [COL_W-1:0] colc_r;
  logic [COL_W-1:0] col_r;
  pixel_t           pix_r;
  logic             emit_r;
  logic             eof_r;
  pixel_t           win_r [9];
  pixel_t           top_q;
  pixel_t           mid_q;
  logic [POS_W-1:0] divq_r;
  logic [WW:0]      rem_r;
  logic [CNT_W-1:0] cnt_r;
  grad_t            gx_r [3];
  grad_t            gy_r [3];
  logic [SQ_W-1:0]  sq_r [3];
  logic [7:0]       root_r [3];
  logic [7:0]       bit_r;

  logic             out_valid_r;
  logic [7:0]       out_red_r;
  logic [7:0]       out_green_r;
  logic [7:0]       out_blue_r;
  logic             out_eof_r;

  pixel_t upper_mem [MAX_WIDTH];
  pixel_t mid_mem [MAX_WIDTH];

  logic [WW-1:0]    w_eff;
  logic [HW-1:0]    h_eff;
  logic [TOT_W-1:0] total;
  logic [COL_W-1:0] col_sel;
  logic [POS_W-1:0] q_pos;
  logic [POS_W-1:0] tot_m1;
  logic             acc;
  logic             drop;
  logic             res_ok;
  logic             restart;
  logic             col_wrap;
  pixel_t           pix_in;
  logic [WW:0]      rem_sh;
  logic             rem_ge;
  pixel_t           wm [9];
  grad_t            gx_c [3];
  grad_t            gy_c [3];
  logic [SQ_W-1:0]  sq_c [3];
  logic [7:0]       root_c [3];
  logic [7:0]       mag_c [3];
  logic             out_free;

  always_comb begin
    if (frame_width_r == '0) begin
      w_eff = WW'(1);
    end else if (32'(frame_width_r) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(frame_width_r);
    end
    if (frame_height_r == '0) begin
      h_eff = HW'(1);
    end else if (32'(frame_height_r) > MAX_HEIGHT) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(frame_height_r);
    end
  end

  assign total    = TOT_W'(w_eff) * TOT_W'(h_eff);
  assign tot_m1   = POS_W'(total) - 1'b1;
  assign col_sel  = (32'(colc_r) >= 32'(w_eff)) ? '0 : colc_r;
  assign col_wrap = (32'(col_sel) + 1 >= 32'(w_eff));
  assign acc      = in_ch.valid && in_ch.ready;
  assign drop     = (in_ch.op == OP_PIXEL) && (pos_r >= POS_W'(total));
  assign res_ok   = (pos_r >= POS_W'(w_eff) + 1'b1);
  assign q_pos    = pos_r - POS_W'(w_eff) - 1'b1;
  assign restart  = res_ok && (q_pos >= tot_m1);
  assign pix_in   = (in_ch.op == OP_DRAIN) ? '0 :
                    pixel_t'({in_ch.in_red, in_ch.in_green, in_ch.in_blue});
  assign rem_sh   = {rem_r[WW-1:0], divq_r[POS_W-1]};
  assign rem_ge   = (rem_sh >= {1'b0, w_eff});
  assign out_free = !out_valid_r || out_ch.ready;

  assign in_ch.ready         = (state_r == S_IDLE);
  assign cfg_ch.ready        = 1'b1;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.out_red      = out_red_r;
  assign out_ch.out_green    = out_green_r;
  assign out_ch.out_blue     = out_blue_r;
  assign out_ch.end_of_frame = out_eof_r;

  always_comb begin
    logic [8:0][7:0] vr;
    logic [8:0][7:0] vg;
    logic [8:0][7:0] vb;
    logic signed [23:0] gxe;
    logic signed [23:0] gye;
    logic [7:0]  t;
    logic [15:0] nn;
    logic [SQ_W-1:0] diff;
    for (int i = 0; i < 9; i++) begin
      wm[i] = win_r[i];
    end
    if (divq_r == '0) begin
      wm[0] = '0; wm[1] = '0; wm[2] = '0;
    end
    if (divq_r == POS_W'(h_eff) - 1'b1) begin
      wm[6] = '0; wm[7] = '0; wm[8] = '0;
    end
    if (rem_r == '0) begin
      wm[0] = '0; wm[3] = '0; wm[6] = '0;
    end
    if (rem_r == (WW+1)'(w_eff) - 1'b1) begin
      wm[2] = '0; wm[5] = '0; wm[8] = '0;
    end
    for (int i = 0; i < 9; i++) begin
      vr[i] = wm[i].red;
      vg[i] = wm[i].green;
      vb[i] = wm[i].blue;
    end
    gx_c[0] = sobel_gx(vr);
    gy_c[0] = sobel_gy(vr);
    gx_c[1] = sobel_gx(vg);
    gy_c[1] = sobel_gy(vg);
    gx_c[2] = sobel_gx(vb);
    gy_c[2] = sobel_gy(vb);
    for (int c = 0; c < 3; c++) begin
      gxe = 24'(gx_r[c]);
      gye = 24'(gy_r[c]);
      sq_c[c] = SQ_W'(gxe * gxe + gye * gye);
      t = root_r[c] | bit_r;
      root_c[c] = (SQ_W'(16'(t) * 16'(t)) <= sq_r[c]) ? t : root_r[c];
      nn = 16'(root_r[c]) * 16'(root_r[c]);
      diff = sq_r[c] - SQ_W'(nn);
      if (sq_r[c] > SAT_LIMIT) begin
        mag_c[c] = MAG_MAX;
      end else if (diff > SQ_W'(root_r[c]) && root_r[c] != MAG_MAX) begin
        mag_c[c] = root_r[c] + 8'd1;
      end else begin
        mag_c[c] = root_r[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc && !drop) begin
      top_q <= upper_mem[col_sel];
      mid_q <= mid_mem[col_sel];
    end
    if (state_r == S_UPD) begin
      upper_mem[col_r] <= mid_q;
      mid_mem[col_r]   <= pix_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      frame_width_r  <= FRAME_WIDTH_RST;
      frame_height_r <= FRAME_HEIGHT_RST;
      pos_r          <= '0;
      colc_r         <= '0;
      out_valid_r    <= 1'b0;
      for (int i = 0; i < 9; i++) begin
        win_r[i] <= '0;
      end
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.index == REG_FRAME_WIDTH) begin
          frame_width_r <= cfg_ch.data[FW_W-1:0];
        end else if (cfg_ch.index == REG_FRAME_HEIGHT) begin
          frame_height_r <= cfg_ch.data[FH_W-1:0];
        end
      end
      if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (acc && !drop) begin
            col_r  <= col_sel;
            pix_r  <= pix_in;
            emit_r <= res_ok && (q_pos <= tot_m1);
            eof_r  <= res_ok && (q_pos == tot_m1);
            divq_r <= q_pos;
            rem_r  <= '0;
            cnt_r  <= CNT_W'(POS_W);
            if (restart) begin
              pos_r  <= '0;
              colc_r <= '0;
            end else begin
              pos_r  <= pos_r + 1'b1;
              colc_r <= col_wrap ? '0 : col_sel + 1'b1;
            end
            state_r <= S_UPD;
          end
        end
        S_UPD: begin
          for (int r = 0; r < 3; r++) begin
            win_r[r*3]     <= win_r[r*3+1];
            win_r[r*3 + 1] <= win_r[r*3+2];
          end
          win_r[2] <= top_q;
          win_r[5] <= mid_q;
          win_r[8] <= pix_r;
          state_r  <= emit_r ? S_DIV : S_IDLE;
        end
        S_DIV: begin
          rem_r  <= rem_ge ? rem_sh - {1'b0, w_eff} : rem_sh;
          divq_r <= {divq_r[POS_W-2:0], rem_ge};
          cnt_r  <= cnt_r - 1'b1;
          if (cnt_r == CNT_W'(1)) begin
            state_r <= S_GRAD;
          end
        end
        S_GRAD: begin
          gx_r    <= gx_c;
          gy_r    <= gy_c;
          state_r <= S_SQ;
        end
        S_SQ: begin
          sq_r    <= sq_c;
          for (int c = 0; c < 3; c++) begin
            root_r[c] <= '0;
          end
          bit_r   <= 8'h80;
          state_r <= S_ROOT;
        end
        S_ROOT: begin
          root_r <= root_c;
          bit_r  <= bit_r >> 1;
          if (bit_r == 8'h01) begin
            state_r <= S_RND;
          end
        end
        S_RND: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_red_r   <= mag_c[0];
            out_green_r <= mag_c[1];
            out_blue_r  <= mag_c[2];
            out_eof_r   <= eof_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/sem_checker.sv =====
// Port-level checker for the Sobel edge block and its bind to the top level.
`default_nettype none
module sem_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_op,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_red,
  input logic [7:0] out_green,
  input logic [7:0] out_blue,
  input logic       out_eof
);

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("Result valid after reset.");

  a_drain_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_op |=> !in_ready)
    else $error("Input still open after a drain transaction.");

  a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("Result appeared without the core being busy.");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid &&
      $stable({out_red, out_green, out_blue, out_eof}))
    else $error("Stalled result changed.");

endmodule

bind sobel_edge_magnitude_3x3_top sem_checker u_sem_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_op     (in_ch.op),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_red   (out_ch.out_red),
  .out_green (out_ch.out_green),
  .out_blue  (out_ch.out_blue),
  .out_eof   (out_ch.end_of_frame)
);
`default_nettype wire

// ===== tb/sv/tb_sobel_edge_magnitude_3x3_top.sv =====
// Self-checking testbench for the streaming 3x3 Sobel edge magnitude block.
module tb_sobel_edge_magnitude_3x3_top;
  import sem_pkg::*;

  localparam int LIMIT_CYCLES = 3000000;
  localparam int SETTLE_CYCLES = 80;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       eof;
  } sobel_result_t;

  logic clk;
  logic rst_n;
  sem_in_if  in_if();
  sem_out_if out_if();
  sem_cfg_if cfg_if();

  sobel_edge_magnitude_3x3_top u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_if),
    .out_ch(out_if),
    .cfg_ch(cfg_if)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  sobel_result_t result_q[$];
  int unsigned   err_count;
  int unsigned   cycle_count;
  int unsigned   items_sent;
  logic          hold_out;

  logic [FW_W-1:0] width_reg;
  logic [FH_W-1:0] height_reg;
  pixel_t          upper_line[DEF_MAX_WIDTH];
  pixel_t          middle_line[DEF_MAX_WIDTH];
  pixel_t          win_pix[9];
  int unsigned     stream_pos;
  int unsigned     col_pos;

  function automatic logic [7:0] rounded_mag(int unsigned s);
    int unsigned n;
    int unsigned t;
    if (s > 65280) return MAG_MAX;
    n = 0;
    for (int b = 128; b != 0; b = b >> 1) begin
      t = n | b;
      if (t * t <= s) n = t;
    end
    if (s - n * n > n) n++;
    return (n > 255) ? MAG_MAX : n[7:0];
  endfunction

  function automatic logic [7:0] chan_mag(logic [7:0] v[9]);
    int kx[9];
    int ky[9];
    int gx;
    int gy;
    kx = '{-1, 0, 1, -2, 0, 2, -1, 0, 1};
    ky = '{-1, -2, -1, 0, 0, 0, 1, 2, 1};
    gx = 0;
    gy = 0;
    for (int i = 0; i < 9; i++) begin
      gx += kx[i] * int'(v[i]);
      gy += ky[i] * int'(v[i]);
    end
    return rounded_mag(int'(gx * gx + gy * gy));
  endfunction

  task automatic predict_sobel(logic op, pixel_t px);
    int unsigned w;
    int unsigned h;
    int unsigned total;
    int unsigned c;
    int unsigned p;
    int unsigned q;
    pixel_t top;
    pixel_t mid;
    pixel_t pix;
    pixel_t wn[9];
    logic [7:0] vr[9];
    logic [7:0] vg[9];
    logic [7:0] vb[9];
    sobel_result_t res;
    w = width_reg;
    h = height_reg;
    if (w < 1) w = 1;
    if (w > DEF_MAX_WIDTH) w = DEF_MAX_WIDTH;
    if (h < 1) h = 1;
    if (h > DEF_MAX_HEIGHT) h = DEF_MAX_HEIGHT;
    total = h * w;
    if (op == OP_PIXEL && stream_pos >= total) return;
    pix = (op == OP_DRAIN) ? '0 : px;
    c = (col_pos >= w) ? 0 : col_pos;
    top = upper_line[c];
    mid = middle_line[c];
    upper_line[c] = mid;
    middle_line[c] = pix;
    for (int r = 0; r < 3; r++) begin
      win_pix[r*3] = win_pix[r*3+1];
      win_pix[r*3+1] = win_pix[r*3+2];
    end
    win_pix[2] = top;
    win_pix[5] = mid;
    win_pix[8] = pix;
    p = stream_pos;
    col_pos = (c + 1 >= w) ? 0 : c + 1;
    stream_pos = p + 1;
    if (p < w + 1) return;
    q = p - w - 1;
    if (q >= total - 1) begin
      stream_pos = 0;
      col_pos = 0;
    end
    if (q > total - 1) return;
    wn = win_pix;
    if (q / w == 0) begin wn[0] = '0; wn[1] = '0; wn[2] = '0; end
    if (q / w == h - 1) begin wn[6] = '0; wn[7] = '0; wn[8] = '0; end
    if (q % w == 0) begin wn[0] = '0; wn[3] = '0; wn[6] = '0; end
    if (q % w == w - 1) begin wn[2] = '0; wn[5] = '0; wn[8] = '0; end
    for (int i = 0; i < 9; i++) begin
      vr[i] = wn[i].red;
      vg[i] = wn[i].green;
      vb[i] = wn[i].blue;
    end
    res.red = chan_mag(vr);
    res.green = chan_mag(vg);
    res.blue = chan_mag(vb);
    res.eof = (q == total - 1);
    result_q.push_back(res);
  endtask

  task automatic report_mismatch(string what);
    $display("tb: mismatch at cycle %0d: %s", cycle_count, what);
    err_count++;
  endtask

  task automatic send_item(logic op, pixel_t px);
    int unsigned gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
    if ($urandom_range(0, 2) == 0) gap = 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.op <= op;
    in_if.in_red <= px.red;
    in_if.in_green <= px.green;
    in_if.in_blue <= px.blue;
    @(negedge clk);
    while (!in_if.ready) @(negedge clk);
    predict_sobel(op, px);
    items_sent++;
    @(posedge clk);
  endtask

  task automatic stop_input();
    in_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_idle();
    stop_input();
    while (result_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= val;
    @(negedge clk);
    while (!cfg_if.ready) @(negedge clk);
    if (idx == REG_FRAME_WIDTH) width_reg = val[FW_W-1:0];
    else if (idx == REG_FRAME_HEIGHT) height_reg = val[FH_W-1:0];
    @(posedge clk);
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_frame(int unsigned w, int unsigned h);
    wait_idle();
    write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(w));
    write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(h));
  endtask

  function automatic pixel_t rand_pixel(int mode);
    pixel_t px;
    px = pixel_t'($urandom());
    if (mode == 1) px = ($urandom_range(0, 1) != 0) ? '1 : '0;
    return px;
  endfunction

  // One frame of w x h pixels and its drain, with optional early drains and surplus pixels.
  task automatic run_frame(int unsigned w, int unsigned h, int early_pct, int surplus_pct,
                           int mode);
    int unsigned steps;
    int unsigned total;
    total = w * h;
    steps = 0;
    while (steps < total + w + 1) begin
      if (steps < total) begin
        if ($urandom_range(0, 99) < early_pct) send_item(OP_DRAIN, rand_pixel(0));
        else send_item(OP_PIXEL, rand_pixel(mode));
      end else begin
        if ($urandom_range(0, 99) < surplus_pct) send_item(OP_PIXEL, rand_pixel(0));
        send_item(OP_DRAIN, rand_pixel(0));
      end
      steps++;
    end
  endtask

  task automatic test_extreme_values();
    set_frame(4, 3);
    send_item(OP_PIXEL, '0);
    send_item(OP_PIXEL, '1);
    send_item(OP_PIXEL, '0);
    send_item(OP_PIXEL, '1);
    send_item(OP_PIXEL, '1);
    send_item(OP_PIXEL, '0);
    send_item(OP_PIXEL, '1);
    send_item(OP_PIXEL, '0);
    send_item(OP_PIXEL, 24'hFF00FF);
    send_item(OP_DRAIN, '1);
    send_item(OP_PIXEL, 24'h00FF00);
    send_item(OP_PIXEL, '1);
    for (int i = 0; i < 5; i++) send_item(OP_DRAIN, '0);
    send_item(OP_PIXEL, '1);
    send_item(OP_PIXEL, 24'h123456);
  endtask

  task automatic test_narrow_frames();
    set_frame(0, 3);
    run_frame(1, 3, 0, 30, 1);
    set_frame(1, 1);
    run_frame(1, 1, 0, 0, 0);
    set_frame(13'h1FFF & ~13'h0800, 13'h1FFF);
    for (int i = 0; i < 24; i++) begin
      if (i % 5 == 0) send_item(OP_DRAIN, rand_pixel(0));
      else send_item(OP_PIXEL, rand_pixel(0));
    end
  endtask

  task automatic test_wide_frame();
    set_frame(13'h07FF, 0);
    for (int i = 0; i < 30; i++) send_item(OP_PIXEL, rand_pixel(1));
    set_frame(DEF_MAX_WIDTH, 2);
    for (int i = 0; i < 30; i++) send_item(OP_PIXEL, rand_pixel(0));
  endtask

  task automatic test_back_pressure();
    set_frame(8, 8);
    hold_out <= 1'b1;
    run_frame(8, 8, 0, 0, 0);
  endtask

  task automatic test_random_frames();
    int unsigned w;
    int unsigned h;
    int unsigned start;
    start = items_sent;
    while (items_sent - start < 580) begin
      w = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      h = $urandom_range(1, 6);
      set_frame(w, h);
      run_frame(w, h, ($urandom_range(0, 3) == 0) ? 10 : 0,
                ($urandom_range(0, 3) == 0) ? 20 : 0, int'($urandom_range(0, 3) == 0));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.op = OP_PIXEL;
    in_if.in_red = '0;
    in_if.in_green = '0;
    in_if.in_blue = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_FRAME_WIDTH;
    cfg_if.data = '0;
    hold_out = 1'b0;
    err_count = 0;
    items_sent = 0;
    width_reg = FRAME_WIDTH_RST;
    height_reg = FRAME_HEIGHT_RST;
    stream_pos = 0;
    col_pos = 0;
    for (int i = 0; i < DEF_MAX_WIDTH; i++) begin
      upper_line[i] = '0;
      middle_line[i] = '0;
    end
    for (int i = 0; i < 9; i++) win_pix[i] = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extreme_values();
    test_narrow_frames();
    test_wide_frame();
    test_back_pressure();
    test_random_frames();
    wait_idle();
    if (err_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    int unsigned gap;
    sobel_result_t exp_res;
    out_if.ready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_out) begin
        out_if.ready <= 1'b0;
        repeat (500) @(posedge clk);
        hold_out <= 1'b0;
      end else begin
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
          out_if.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      out_if.ready <= 1'b1;
      @(negedge clk);
      while (!out_if.valid) @(negedge clk);
      if (result_q.size() == 0) begin
        report_mismatch("result transaction with nothing expected");
      end else begin
        exp_res = result_q.pop_front();
        if (out_if.out_red !== exp_res.red)
          report_mismatch($sformatf("red %0h, expected %0h", out_if.out_red, exp_res.red));
        if (out_if.out_green !== exp_res.green)
          report_mismatch($sformatf("green %0h, expected %0h", out_if.out_green,
                                    exp_res.green));
        if (out_if.out_blue !== exp_res.blue)
          report_mismatch($sformatf("blue %0h, expected %0h", out_if.out_blue, exp_res.blue));
        if (out_if.end_of_frame !== exp_res.eof)
          report_mismatch($sformatf("end_of_frame %0b, expected %0b", out_if.end_of_frame,
                                    exp_res.eof));
      end
      @(posedge clk);
    end
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

endmodule
